### rtl/mqbr_pkg.sv
// ----------------------------------------------------------------------------
// mqbr_pkg
// Shared types and fixed field widths for the multi-queue byte ring.
// ----------------------------------------------------------------------------
package mqbr_pkg;

  // Field widths fixed by the interface
  localparam int CMD_W  = 2;
  localparam int ID_W   = 8;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 11;

  // Burst counter saturates at the top of its field
  localparam logic [CNT_W-1:0] BURST_MAX = {CNT_W{1'b1}};

  // Reset value of the tunnel base register
  localparam logic [ID_W-1:0] TUNNEL_BASE_RST = 8'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_RESET   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_t;

endpackage

### rtl/multi_queue_byte_ring.sv
// ----------------------------------------------------------------------------
// multi_queue_byte_ring
// Per-connection transmit byte rings held in one shared byte RAM, with the
// head/tail pointer pairs in a small pointer RAM.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | input     | in_valid/in_stall  | command, conn_id, data, counts
//  out_    | output    | out_valid/out_stall| status and counts of one ring
//  cfg_    | input     | cfg_valid/cfg_ready| tunnel base id
//
//  Each word has its pointer pair read as it is accepted, then its byte RAM
//  access in the execute stage, then its result registered in the final
//  stage; a new word is taken only as the previous one leaves that stage.
//  A stalled result holds the block in its final stage until taken.
//  Reset (rst_n, synchronous) clears the pointer valid bits and the burst
//  count and restores the tunnel base; there is no clearing pass over either
//  RAM. Byte RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module multi_queue_byte_ring
  import mqbr_pkg::*;
#(
  parameter int RING_BYTES   = 2048,
  parameter int DIRECT_SLOTS = 5,
  parameter int TUNNEL_SLOTS = 3
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [ID_W-1:0]   in_conn_id,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last,
  input  logic [CNT_W-1:0]  in_count,
  input  logic [CNT_W-1:0]  in_offset,

  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_conn_valid,
  output logic              out_accepted,
  output logic [CNT_W-1:0]  out_burst_total,
  output logic [BYTE_W-1:0] out_read_byte,
  output logic [CNT_W-1:0]  out_used_count,
  output logic [CNT_W-1:0]  out_free_count,
  output logic [CNT_W-1:0]  out_contig_count,
  output logic              out_advance_clipped,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ID_W-1:0]   cfg_data
);

  localparam int SLOT_TOTAL = DIRECT_SLOTS + TUNNEL_SLOTS;
  localparam int SLOT_W     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
  localparam int PTR_W      = $clog2(RING_BYTES);
  localparam int SUM_W      = PTR_W + 1;
  localparam int CMP_W      = (PTR_W > CNT_W) ? PTR_W : CNT_W;
  localparam int RING_DEPTH = SLOT_TOTAL * RING_BYTES;
  localparam int RADDR_W    = $clog2(RING_DEPTH);

  localparam logic [SUM_W-1:0]   RING_SUM   = SUM_W'(RING_BYTES);
  localparam logic [PTR_W-1:0]   RING_LAST  = PTR_W'(RING_BYTES - 1);
  localparam logic [ID_W:0]      DIRECT_LIM = (ID_W+1)'(DIRECT_SLOTS);
  localparam logic [ID_W:0]      TUNNEL_LIM = (ID_W+1)'(TUNNEL_SLOTS);
  localparam logic [SLOT_W-1:0]  TUNNEL_OFS = SLOT_W'(DIRECT_SLOTS);
  localparam logic [RADDR_W-1:0] RING_STEP  = RADDR_W'(RING_BYTES);

  // Wrap a pointer sum known to stay below twice the ring size
  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] s);
    logic [PTR_W-1:0] r;
    if (s >= RING_SUM) begin
      r = PTR_W'(s - RING_SUM);
    end else begin
      r = PTR_W'(s);
    end
    return r;
  endfunction

  // Bytes between tail and head
  function automatic logic [PTR_W-1:0] used_of(input logic [PTR_W-1:0] h,
                                               input logic [PTR_W-1:0] t);
    logic [SUM_W-1:0] d;
    d = {1'b0, h} - {1'b0, t};
    if (h < t) begin
      d = d + RING_SUM;
    end
    return PTR_W'(d);
  endfunction

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;
  logic   out_free;
  logic   in_accept;
  logic   exec_en;
  logic   fin_load;

  assign out_free  = !out_valid || !out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = in_valid ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    exec_en  = 1'b0;
    fin_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_EXEC: begin
        exec_en = 1'b1;
      end
      ST_FIN: begin
        in_stall = !out_free;
        fin_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [ID_W-1:0] tunnel_base_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tunnel_base_r <= TUNNEL_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      tunnel_base_r <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Map the connection id to a slot
  // --------------------------------------------------------------------------
  logic              id_direct;
  logic              id_tunnel;
  logic [ID_W-1:0]   id_diff;
  logic [SLOT_W-1:0] in_slot;

  always_comb begin
    id_diff   = in_conn_id - tunnel_base_r;
    id_direct = {1'b0, in_conn_id} < DIRECT_LIM;
    id_tunnel = (in_conn_id >= tunnel_base_r) && ({1'b0, id_diff} < TUNNEL_LIM);
    if (id_direct) begin
      in_slot = SLOT_W'(in_conn_id);
    end else if (id_tunnel) begin
      in_slot = TUNNEL_OFS + SLOT_W'(id_diff);
    end else begin
      in_slot = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Capture the word and read its pointer pair
  // --------------------------------------------------------------------------
  cmd_t               cmd_r;
  logic [BYTE_W-1:0]  data_r;
  logic               last_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   off_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [RADDR_W-1:0] base_r;
  logic               cvalid_r;

  logic [2*PTR_W-1:0] ptr_mem [SLOT_TOTAL];
  logic               ptr_vld_r [SLOT_TOTAL];
  logic [2*PTR_W-1:0] ptr_rd_r;
  logic               ptr_rd_vld_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r        <= cmd_t'(in_command);
      data_r       <= in_data_byte;
      last_r       <= in_last;
      cnt_r        <= in_count;
      off_r        <= in_offset;
      slot_r       <= in_slot;
      base_r       <= RADDR_W'(in_slot) * RING_STEP;
      cvalid_r     <= id_direct || id_tunnel;
      ptr_rd_r     <= ptr_mem[in_slot];
      ptr_rd_vld_r <= ptr_vld_r[in_slot];
    end
  end

  // --------------------------------------------------------------------------
  // Execute the command on the pointer pair
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0]   cur_head;
  logic [PTR_W-1:0]   cur_tail;
  logic [PTR_W-1:0]   cur_used;
  logic [PTR_W-1:0]   new_head;
  logic [PTR_W-1:0]   new_tail;
  logic [PTR_W-1:0]   rd_pos;
  logic               ring_full;
  logic               rd_ok;
  logic               adv_over;
  logic               ex_acc;
  logic               ex_clip;
  logic               ring_we;
  logic               ring_re;
  logic [RADDR_W-1:0] ring_addr;

  always_comb begin
    cur_head  = ptr_rd_vld_r ? ptr_rd_r[2*PTR_W-1:PTR_W] : '0;
    cur_tail  = ptr_rd_vld_r ? ptr_rd_r[PTR_W-1:0] : '0;
    cur_used  = used_of(cur_head, cur_tail);
    ring_full = (cur_used == RING_LAST);
    rd_ok     = CMP_W'(off_r) < CMP_W'(cur_used);
    adv_over  = CMP_W'(cnt_r) > CMP_W'(cur_used);
    rd_pos    = wrap_ptr({1'b0, cur_tail} + SUM_W'(off_r));
    new_head  = cur_head;
    new_tail  = cur_tail;
    ex_acc    = 1'b0;
    ex_clip   = 1'b0;
    ring_we   = 1'b0;
    ring_re   = 1'b0;
    case (cmd_r)
      CMD_WRITE: begin
        if (!ring_full) begin
          new_head = (cur_head == RING_LAST) ? '0 : cur_head + 1'b1;
          ex_acc   = 1'b1;
          ring_we  = cvalid_r;
        end
      end
      CMD_READ: begin
        ex_acc  = rd_ok;
        ring_re = rd_ok && cvalid_r;
      end
      CMD_ADVANCE: begin
        if (adv_over) begin
          new_tail = cur_head;
          ex_clip  = 1'b1;
        end else begin
          new_tail = wrap_ptr({1'b0, cur_tail} + SUM_W'(cnt_r));
          ex_acc   = 1'b1;
        end
      end
      CMD_RESET: begin
        new_tail = cur_head;
        ex_acc   = 1'b1;
      end
      default: begin
        ex_acc = 1'b0;
      end
    endcase
    ring_addr = base_r + RADDR_W'(ring_we ? cur_head : rd_pos);
  end

  // Write back the pointer pair
  always_ff @(posedge clk) begin
    if (exec_en && cvalid_r) begin
      ptr_mem[slot_r] <= {new_head, new_tail};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_TOTAL; i++) begin
        ptr_vld_r[i] <= 1'b0;
      end
    end else if (exec_en && cvalid_r) begin
      ptr_vld_r[slot_r] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Byte RAM: at most one access per word
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  logic [BYTE_W-1:0] ring_rd_r;

  always_ff @(posedge clk) begin
    if (exec_en && ring_we) begin
      ring_mem[ring_addr] <= data_r;
    end
    if (exec_en && ring_re) begin
      ring_rd_r <= ring_mem[ring_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Burst count
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] burst_r;
  logic [CNT_W-1:0] burst_inc;

  always_comb begin
    burst_inc = burst_r;
    if (cmd_r == CMD_WRITE && cvalid_r && ex_acc && burst_r != BURST_MAX) begin
      burst_inc = burst_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r <= '0;
    end else if (exec_en) begin
      burst_r <= (cmd_r == CMD_WRITE && last_r) ? '0 : burst_inc;
    end
  end

  // --------------------------------------------------------------------------
  // Hold the execute results for the status stage
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0] fin_head_r;
  logic [PTR_W-1:0] fin_tail_r;
  logic             fin_acc_r;
  logic             fin_clip_r;
  logic             fin_rd_r;
  logic [CNT_W-1:0] fin_total_r;

  always_ff @(posedge clk) begin
    if (exec_en) begin
      fin_head_r  <= new_head;
      fin_tail_r  <= new_tail;
      fin_acc_r   <= ex_acc && cvalid_r;
      fin_clip_r  <= ex_clip && cvalid_r;
      fin_rd_r    <= ring_re;
      fin_total_r <= burst_inc;
    end
  end

  // --------------------------------------------------------------------------
  // Occupancy counts and result register
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0] fin_used;
  logic [PTR_W-1:0] fin_free;
  logic [SUM_W-1:0] fin_to_end;
  logic [PTR_W-1:0] fin_contig;

  always_comb begin
    fin_used   = used_of(fin_head_r, fin_tail_r);
    fin_free   = RING_LAST - fin_used;
    fin_to_end = RING_SUM - {1'b0, fin_tail_r};
    fin_contig = ({1'b0, fin_used} < fin_to_end) ? fin_used : PTR_W'(fin_to_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_conn_valid      <= cvalid_r;
      out_accepted        <= fin_acc_r;
      out_burst_total     <= fin_total_r;
      out_read_byte       <= fin_rd_r ? ring_rd_r : '0;
      out_used_count      <= cvalid_r ? CNT_W'(fin_used) : '0;
      out_free_count      <= cvalid_r ? CNT_W'(fin_free) : '0;
      out_contig_count    <= cvalid_r ? CNT_W'(fin_contig) : '0;
      out_advance_clipped <= fin_clip_r;
    end
  end

`ifndef ASSERT_OFF
  // An accepted word always moves into the execute stage
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_EXEC)
    else $error("accepted word did not enter execute");

  // Execute is always followed by the status stage
  a_exec_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> state_r == ST_FIN)
    else $error("execute not followed by status stage");

  // An unmapped id reports nothing accepted and an empty ring
  a_invalid_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_conn_valid) |->
      (!out_accepted && out_used_count == '0 && !out_advance_clipped))
    else $error("unmapped id reported ring activity");

  // Used plus free always covers the ring less the spare byte
  a_used_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_conn_valid) |->
      (CNT_W'(out_used_count + out_free_count) == CNT_W'(RING_BYTES - 1)))
    else $error("used and free counts disagree");
`endif

endmodule
